// ----- design/scie_pkg.sv -----
package scie_pkg;

    typedef enum logic [7:0] {
        OP_NOP     = 8'h00,
        OP_ADD_V   = 8'h01,
        OP_ADD_R   = 8'h02,
        OP_SUB_V   = 8'h03,
        OP_SUB_R   = 8'h04,
        OP_MUL_V   = 8'h05,
        OP_MUL_R   = 8'h06,
        OP_INC     = 8'h07,
        OP_DEC     = 8'h08,
        OP_AND_V   = 8'h09,
        OP_AND_R   = 8'h0A,
        OP_OR_V    = 8'h0B,
        OP_OR_R    = 8'h0C,
        OP_XOR_V   = 8'h0D,
        OP_XOR_R   = 8'h0E,
        OP_NAND_V  = 8'h0F,
        OP_NAND_R  = 8'h10,
        OP_NOR_V   = 8'h11,
        OP_NOR_R   = 8'h12,
        OP_XNOR_V  = 8'h13,
        OP_XNOR_R  = 8'h14,
        OP_NOT     = 8'h15,
        OP_MOV_RV  = 8'h16,
        OP_MOV_RR  = 8'h17,
        OP_MOV_RM  = 8'h18,
        OP_MOV_MR  = 8'h19,
        OP_MOV_MV  = 8'h1A,
        OP_CMP_RR  = 8'h1B,
        OP_CMP_RV  = 8'h1C,
        OP_JMP     = 8'h1D,
        OP_JE      = 8'h1E,
        OP_JL      = 8'h1F,
        OP_JG      = 8'h20,
        OP_MOV_IV  = 8'hA0,
        OP_MOV_RI  = 8'hA1,
        OP_MOV_IR  = 8'hA2,
        OP_IN      = 8'hFD,
        OP_OUT     = 8'hFE,
        OP_HLT     = 8'hFF
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_OP  = 2'd1,
        ST_BAD_ADR = 2'd2
    } status_t;

    localparam logic [2:0] IP_INDEX = 3'd5;
    localparam int FLAG_EQ = 0;
    localparam int FLAG_LT = 1;
    localparam int FLAG_GT = 2;

    function automatic logic [3:0] instr_length(input logic [7:0] op);
        logic [3:0] len;
        len = 4'd1;
        case (op) inside
            OP_INC, OP_DEC, OP_NOT, OP_IN, OP_OUT:                 len = 4'd2;
            OP_ADD_V, OP_SUB_V, OP_MUL_V, OP_AND_V, OP_OR_V, OP_XOR_V,
            OP_NAND_V, OP_NOR_V, OP_XNOR_V, OP_MOV_RV, OP_MOV_RM,
            OP_MOV_MR, OP_MOV_IV, OP_CMP_RV:                       len = 4'd6;
            OP_ADD_R, OP_SUB_R, OP_MUL_R, OP_AND_R, OP_OR_R, OP_XOR_R,
            OP_NAND_R, OP_NOR_R, OP_XNOR_R, OP_MOV_RR, OP_MOV_RI,
            OP_MOV_IR, OP_CMP_RR:                                  len = 4'd3;
            OP_MOV_MV:                                             len = 4'd9;
            OP_JMP, OP_JE, OP_JL, OP_JG:                           len = 4'd5;
            default:                                               len = 4'd1;
        endcase
        return len;
    endfunction

    function automatic logic is_known(input logic [7:0] op);
        logic k;
        k = 1'b0;
        case (op) inside
            [8'h00:8'h20], OP_MOV_IV, OP_MOV_RI, OP_MOV_IR, OP_IN, OP_OUT,
            OP_HLT: k = 1'b1;
            default: k = 1'b0;
        endcase
        return k;
    endfunction

endpackage

// ----- design/scie_ram.sv -----
module scie_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- design/small_cpu_instruction_execute_core.sv -----
// Instruction execute core for a small 32-bit register machine. Each input
// transaction carries one decoded instruction; each produces exactly one result
// transaction (next ip, out port, halted, status). The block holds eight 32-bit
// registers (index 5 is ip), the compare flags, a halt mark and a data RAM of
// RAM_WORDS words. The register file and the data RAM are synchronous memories
// with a registered read. An instruction is accepted and its reads launched
// into stage 1; it executes and writes back when it leaves stage 1, which also
// loads the output register, so the result on the m_ side is registered. A new
// transaction is taken every cycle while no result waits on m_ready, except
// after a register-indirect load (mov r,[r]): it needs its address from the
// register file before the RAM read can start, so it holds the input for an
// address phase that launches the RAM read at the register value.
// A write landing at the same edge as a read of the same register or RAM word
// is forwarded to that read. While a result waits on m_ready nothing executes
// and s_ready is held low once stage 1 holds an instruction. After reset a
// clearing pass writes zero to every RAM word and register; s_ready stays low
// during it. Multiply is a single 32x32 low-word product.
module small_cpu_instruction_execute_core #(
    parameter int RAM_WORDS = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_opcode,
    input  logic [2:0]  s_first_reg,
    input  logic [2:0]  s_second_reg,
    input  logic [31:0] s_imm_value,
    input  logic [31:0] s_mem_address,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_next_ip,
    output logic        m_out_valid,
    output logic [31:0] m_out_value,
    output logic        m_halted,
    output logic [1:0]  m_status
);
    import scie_pkg::*;

    localparam int AW = $clog2(RAM_WORDS);
    localparam logic [31:0] ADDR_LIMIT = 32'(RAM_WORDS - 4);

    // clearing pass
    logic          clr_busy_reg;
    logic [AW-1:0] clr_cnt_reg;

    // stage 1 (register/RAM read) registers
    logic          s1_valid_reg;
    logic [7:0]    s1_op_reg;
    logic [2:0]    s1_ra_reg, s1_rb_reg;
    logic [31:0]   s1_imm_reg, s1_addr_reg;
    // indirect load: address resolved, RAM read launched
    logic          ri_phase_reg;

    // output register
    logic          o_valid_reg;
    logic [31:0]   o_ip_reg, o_val_reg;
    logic          o_ov_reg, o_halt_reg;
    logic [1:0]    o_st_reg;

    logic [2:0]    flags_reg;
    logic          halt_reg;

    // ip lives in a flop, not in the register file
    logic [31:0]   ip_reg;

    // memory ports
    logic          rf_we;
    logic [2:0]    rf_wa;
    logic [31:0]   rf_wd;
    logic [2:0]    rf_ra_a, rf_ra_b;
    logic          ram_we;
    logic [AW-1:0] ram_wa;
    logic [31:0]   ram_wd;
    logic [AW-1:0] ram_ra;

    logic [31:0]   rfa_q, rfb_q, ram_q;
    logic [31:0]   ra_val, rb_val, mem_val;

    // forwarding snapshots of the write landing at the read edge
    logic          fa_reg, fb_reg, fm_reg;
    logic [31:0]   fwa_reg, fwb_reg, fwm_reg;

    logic          adv;
    logic          ri_wait;
    logic          ex_fire;
    logic          take;

    // execute
    logic [31:0]   ipc, a_op, opb, res, nip;
    logic          wr_r, mv_r, jumped, ov;
    logic [31:0]   ovv;
    status_t       st;
    logic [2:0]    flags_next;
    logic          halt_next;
    logic          ok_d, ok_i;
    logic          wr_m;
    logic [AW-1:0] mem_wa;
    logic [31:0]   mem_wd;

    assign adv     = !(o_valid_reg && !m_ready);
    assign ri_wait = s1_valid_reg && (s1_op_reg == OP_MOV_RI) && !ri_phase_reg;
    assign ex_fire = s1_valid_reg && adv && !ri_wait;
    assign s_ready = !clr_busy_reg && (!s1_valid_reg || ex_fire);
    assign take    = s_valid && s_ready;

    // reads follow the new transaction when one is taken, else re-read stage 1
    assign rf_ra_a = take ? s_first_reg  : s1_ra_reg;
    assign rf_ra_b = take ? s_second_reg : s1_rb_reg;

    always_comb begin
        if (ri_wait)   ram_ra = opb[AW-1:0];
        else if (take) ram_ra = s_mem_address[AW-1:0];
        else           ram_ra = s1_addr_reg[AW-1:0];
    end

    // register file: two read ports as two memories sharing one write
    scie_ram #(.WIDTH(32), .DEPTH(8)) u_rf_a (
        .aclk, .we(rf_we), .waddr(rf_wa), .wdata(rf_wd),
        .raddr(rf_ra_a), .rdata(rfa_q));
    scie_ram #(.WIDTH(32), .DEPTH(8)) u_rf_b (
        .aclk, .we(rf_we), .waddr(rf_wa), .wdata(rf_wd),
        .raddr(rf_ra_b), .rdata(rfb_q));

    scie_ram #(.WIDTH(32), .DEPTH(RAM_WORDS)) u_ram (
        .aclk, .we(ram_we), .waddr(ram_wa), .wdata(ram_wd),
        .raddr(ram_ra), .rdata(ram_q));

    assign ra_val  = fa_reg ? fwa_reg : rfa_q;
    assign rb_val  = fb_reg ? fwb_reg : rfb_q;
    assign mem_val = fm_reg ? fwm_reg : ram_q;

    // ip reads as the address of the instruction's last byte
    assign ipc  = ip_reg + 32'(instr_length(s1_op_reg)) - 32'd1;
    assign a_op = (s1_ra_reg == IP_INDEX) ? ipc : ra_val;
    assign opb  = (s1_rb_reg == IP_INDEX) ? ipc : rb_val;

    function automatic logic [2:0] cmpf(input logic [31:0] x, input logic [31:0] y);
        if (x == y) return 3'b001;
        if (x < y)  return 3'b010;
        return 3'b100;
    endfunction

    always_comb begin
        ok_d       = s1_addr_reg <= ADDR_LIMIT;
        ok_i       = 1'b0;
        res        = 32'd0;
        wr_r       = 1'b0;
        mv_r       = 1'b0;
        jumped     = 1'b0;
        ov         = 1'b0;
        ovv        = 32'd0;
        st         = ST_OK;
        flags_next = flags_reg;
        halt_next  = 1'b0;
        wr_m       = 1'b0;
        mem_wa     = s1_addr_reg[AW-1:0];
        mem_wd     = s1_imm_reg;
        case (s1_op_reg)
            OP_ADD_V:  begin res = a_op + s1_imm_reg;      wr_r = 1'b1; end
            OP_ADD_R:  begin res = a_op + opb;             wr_r = 1'b1; end
            OP_SUB_V:  begin res = a_op - s1_imm_reg;      wr_r = 1'b1; end
            OP_SUB_R:  begin res = a_op - opb;             wr_r = 1'b1; end
            OP_MUL_V:  begin res = a_op * s1_imm_reg;      wr_r = 1'b1; end
            OP_MUL_R:  begin res = a_op * opb;             wr_r = 1'b1; end
            OP_INC:    begin res = a_op + 32'd1;           wr_r = 1'b1; end
            OP_DEC:    begin res = a_op - 32'd1;           wr_r = 1'b1; end
            OP_AND_V:  begin res = a_op & s1_imm_reg;      wr_r = 1'b1; end
            OP_AND_R:  begin res = a_op & opb;             wr_r = 1'b1; end
            OP_OR_V:   begin res = a_op | s1_imm_reg;      wr_r = 1'b1; end
            OP_OR_R:   begin res = a_op | opb;             wr_r = 1'b1; end
            OP_XOR_V:  begin res = a_op ^ s1_imm_reg;      wr_r = 1'b1; end
            OP_XOR_R:  begin res = a_op ^ opb;             wr_r = 1'b1; end
            OP_NAND_V: begin res = ~(a_op & s1_imm_reg);   wr_r = 1'b1; end
            OP_NAND_R: begin res = ~(a_op & opb);          wr_r = 1'b1; end
            OP_NOR_V:  begin res = ~(a_op | s1_imm_reg);   wr_r = 1'b1; end
            OP_NOR_R:  begin res = ~(a_op | opb);          wr_r = 1'b1; end
            OP_XNOR_V: begin res = ~(a_op ^ s1_imm_reg);   wr_r = 1'b1; end
            OP_XNOR_R: begin res = ~(a_op ^ opb);          wr_r = 1'b1; end
            OP_NOT:    begin res = ~a_op;                  wr_r = 1'b1; end
            OP_MOV_RV: begin res = s1_imm_reg; wr_r = 1'b1; mv_r = 1'b1; end
            OP_MOV_RR: begin res = opb;        wr_r = 1'b1; mv_r = 1'b1; end
            OP_MOV_RM: begin
                wr_r = 1'b1;
                mv_r = 1'b1;
                res  = ok_d ? mem_val : 32'd0;
                if (!ok_d) st = ST_BAD_ADR;
            end
            OP_MOV_MR: begin
                mem_wd = a_op;
                if (ok_d) wr_m = 1'b1; else st = ST_BAD_ADR;
            end
            OP_MOV_MV: begin
                if (ok_d) wr_m = 1'b1; else st = ST_BAD_ADR;
            end
            OP_MOV_IV: begin
                ok_i   = a_op <= ADDR_LIMIT;
                mem_wa = a_op[AW-1:0];
                if (ok_i) wr_m = 1'b1; else st = ST_BAD_ADR;
            end
            OP_MOV_RI: begin
                ok_i = s1_addr_reg <= ADDR_LIMIT;  // address captured from rb
                res  = mem_val;
                mv_r = 1'b1;
                if (ok_i) wr_r = 1'b1; else st = ST_BAD_ADR;
            end
            OP_MOV_IR: begin
                ok_i   = a_op <= ADDR_LIMIT;
                mem_wa = a_op[AW-1:0];
                mem_wd = opb;
                if (ok_i) wr_m = 1'b1; else st = ST_BAD_ADR;
            end
            OP_CMP_RR: flags_next = cmpf(a_op, opb);
            OP_CMP_RV: flags_next = cmpf(a_op, s1_imm_reg);
            OP_JMP:    jumped = 1'b1;
            OP_JE:     jumped = flags_reg[FLAG_EQ];
            OP_JL:     jumped = flags_reg[FLAG_LT];
            OP_JG:     jumped = flags_reg[FLAG_GT];
            OP_OUT:    begin ov = 1'b1; ovv = a_op; end
            OP_HLT:    halt_next = 1'b1;
            default:   if (!is_known(s1_op_reg)) st = ST_BAD_OP;
        endcase
        // a move into ip jumps; any other write to ip still advances by one
        if (jumped) begin
            nip = s1_imm_reg;
        end else if (wr_r && s1_ra_reg == IP_INDEX) begin
            nip = mv_r ? res : res + 32'd1;
        end else begin
            nip = ipc + 32'd1;
        end
        if (halt_reg) begin
            nip        = ip_reg;
            wr_r       = 1'b0;
            wr_m       = 1'b0;
            ov         = 1'b0;
            ovv        = 32'd0;
            st         = ST_OK;
            flags_next = flags_reg;
        end
    end

    assign rf_we  = (ex_fire && wr_r && s1_ra_reg != IP_INDEX) ||
                    (clr_busy_reg && clr_cnt_reg <= AW'(7));
    assign rf_wa  = clr_busy_reg ? clr_cnt_reg[2:0] : s1_ra_reg;
    assign rf_wd  = clr_busy_reg ? 32'd0 : res;
    assign ram_we = (ex_fire && wr_m) || clr_busy_reg;
    assign ram_wa = clr_busy_reg ? clr_cnt_reg : mem_wa;
    assign ram_wd = clr_busy_reg ? 32'd0 : mem_wd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
            s1_valid_reg <= 1'b0;
            ri_phase_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
            flags_reg    <= '0;
            halt_reg     <= 1'b0;
            ip_reg       <= '0;
            fa_reg       <= 1'b0;
            fb_reg       <= 1'b0;
            fm_reg       <= 1'b0;
        end else begin
            if (clr_busy_reg) begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(RAM_WORDS - 1)) clr_busy_reg <= 1'b0;
            end
            // the read launched at this edge still sees the old word
            fa_reg  <= rf_we && (rf_wa == rf_ra_a);
            fb_reg  <= rf_we && (rf_wa == rf_ra_b);
            fwa_reg <= rf_wd;
            fwb_reg <= rf_wd;
            fm_reg  <= ram_we && (ram_wa == ram_ra);
            fwm_reg <= ram_wd;
            if (ex_fire) begin
                flags_reg <= flags_next;
                ip_reg    <= nip;
                if (halt_next) halt_reg <= 1'b1;
            end
            if (adv) begin
                o_valid_reg <= ex_fire;
                if (ex_fire) begin
                    o_ip_reg   <= nip;
                    o_ov_reg   <= ov;
                    o_val_reg  <= ovv;
                    o_halt_reg <= halt_reg | halt_next;
                    o_st_reg   <= st;
                end
            end
            if (take) begin
                s1_valid_reg <= 1'b1;
                s1_op_reg    <= s_opcode;
                s1_ra_reg    <= s_first_reg;
                s1_rb_reg    <= s_second_reg;
                s1_imm_reg   <= s_imm_value;
                s1_addr_reg  <= s_mem_address;
                ri_phase_reg <= 1'b0;
            end else if (ri_wait) begin
                // address phase: RAM read at the register value starts now
                ri_phase_reg <= 1'b1;
                s1_addr_reg  <= opb;
            end else if (ex_fire) begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid     = o_valid_reg;
    assign m_next_ip   = o_ip_reg;
    assign m_out_valid = o_ov_reg;
    assign m_out_value = o_val_reg;
    assign m_halted    = o_halt_reg;
    assign m_status    = o_st_reg;
endmodule

// ----- design/scie_checker.sv -----
module scie_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_next_ip,
    input logic        m_halted,
    input logic [1:0]  m_status,
    input logic        m_out_valid
);
    import scie_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_next_ip))
        else $error("result dropped under stall");
    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_halted ##1 m_valid |-> m_halted)
        else $error("halt mark cleared");
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status <= ST_BAD_ADR)
        else $error("bad status code");
    a_halt_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_halted && m_out_valid |-> m_status == ST_OK)
        else $error("out with bad status");
endmodule

bind small_cpu_instruction_execute_core scie_checker u_scie_checker (.*);

// ----- dv/tb.sv -----
`timescale 1ns / 100ps

module tb;
    import scie_pkg::*;

    localparam int RAM_WORDS  = 4096;
    localparam int ADDR_TOP   = RAM_WORDS - 4;   // highest valid word address
    localparam int STALL_LIMIT = 20000;          // covers the RAM clearing pass
    localparam logic [7:0] SPARE_OP = 8'h21;     // first undefined opcode

    typedef struct packed {
        logic [31:0] next_ip;
        logic        out_valid;
        logic [31:0] out_value;
        logic        halted;
        status_t     status;
    } exec_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_opcode = '0;
    logic [2:0]  s_first_reg = '0;
    logic [2:0]  s_second_reg = '0;
    logic [31:0] s_imm_value = '0;
    logic [31:0] s_mem_address = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_next_ip;
    logic        m_out_valid;
    logic [31:0] m_out_value;
    logic        m_halted;
    logic [1:0]  m_status;

    small_cpu_instruction_execute_core #(.RAM_WORDS(RAM_WORDS)) dut (.*);

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Machine state mirrored by the predictor.
    logic [31:0] cpu_regs [8];
    logic [2:0]  cmp_flags;
    logic        cpu_halted;
    logic [31:0] data_mem [RAM_WORDS];

    exec_result_t pending_results[$];
    int  error_count = 0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;

    opcode_t known_ops[] = '{OP_NOP, OP_ADD_V, OP_ADD_R, OP_SUB_V, OP_SUB_R, OP_MUL_V,
        OP_MUL_R, OP_INC, OP_DEC, OP_AND_V, OP_AND_R, OP_OR_V, OP_OR_R, OP_XOR_V,
        OP_XOR_R, OP_NAND_V, OP_NAND_R, OP_NOR_V, OP_NOR_R, OP_XNOR_V, OP_XNOR_R,
        OP_NOT, OP_MOV_RV, OP_MOV_RR, OP_MOV_RM, OP_MOV_MR, OP_MOV_MV, OP_CMP_RR,
        OP_CMP_RV, OP_JMP, OP_JE, OP_JL, OP_JG, OP_MOV_IV, OP_MOV_RI, OP_MOV_IR,
        OP_IN, OP_OUT};

    // Byte length of each encoding; undefined opcodes count as one byte.
    function automatic logic [31:0] op_bytes(logic [7:0] op);
        case (op)
            OP_INC, OP_DEC, OP_NOT, OP_IN, OP_OUT: return 2;
            OP_ADD_V, OP_SUB_V, OP_MUL_V, OP_AND_V, OP_OR_V, OP_XOR_V, OP_NAND_V,
            OP_NOR_V, OP_XNOR_V, OP_MOV_RV, OP_MOV_RM, OP_MOV_MR, OP_MOV_IV,
            OP_CMP_RV: return 6;
            OP_ADD_R, OP_SUB_R, OP_MUL_R, OP_AND_R, OP_OR_R, OP_XOR_R, OP_NAND_R,
            OP_NOR_R, OP_XNOR_R, OP_MOV_RR, OP_MOV_RI, OP_MOV_IR,
            OP_CMP_RR: return 3;
            OP_MOV_MV: return 9;
            OP_JMP, OP_JE, OP_JL, OP_JG: return 5;
            default: return 1;
        endcase
    endfunction

    function automatic logic [2:0] compare_u(logic [31:0] x, logic [31:0] y);
        if (x == y) return 3'b001 << FLAG_EQ;
        if (x < y) return 3'b001 << FLAG_LT;
        return 3'b001 << FLAG_GT;
    endfunction

    // Executes one instruction against the mirrored state.
    function automatic exec_result_t execute_instr(logic [7:0] op, logic [2:0] ra,
            logic [2:0] rb, logic [31:0] imm, logic [31:0] addr);
        exec_result_t res;
        logic jumped;
        logic [31:0] ptr;
        res = '0;
        jumped = 1'b0;
        if (cpu_halted) begin
            res.next_ip = cpu_regs[IP_INDEX];
            res.halted = 1'b1;
            return res;
        end
        // ip reads as the last byte of this instruction
        cpu_regs[IP_INDEX] = cpu_regs[IP_INDEX] + op_bytes(op) - 1;
        res.status = ST_OK;
        case (op)
            OP_NOP, OP_IN: ;
            OP_ADD_V:  cpu_regs[ra] = cpu_regs[ra] + imm;
            OP_ADD_R:  cpu_regs[ra] = cpu_regs[ra] + cpu_regs[rb];
            OP_SUB_V:  cpu_regs[ra] = cpu_regs[ra] - imm;
            OP_SUB_R:  cpu_regs[ra] = cpu_regs[ra] - cpu_regs[rb];
            OP_MUL_V:  cpu_regs[ra] = cpu_regs[ra] * imm;
            OP_MUL_R:  cpu_regs[ra] = cpu_regs[ra] * cpu_regs[rb];
            OP_INC:    cpu_regs[ra] = cpu_regs[ra] + 1;
            OP_DEC:    cpu_regs[ra] = cpu_regs[ra] - 1;
            OP_AND_V:  cpu_regs[ra] = cpu_regs[ra] & imm;
            OP_AND_R:  cpu_regs[ra] = cpu_regs[ra] & cpu_regs[rb];
            OP_OR_V:   cpu_regs[ra] = cpu_regs[ra] | imm;
            OP_OR_R:   cpu_regs[ra] = cpu_regs[ra] | cpu_regs[rb];
            OP_XOR_V:  cpu_regs[ra] = cpu_regs[ra] ^ imm;
            OP_XOR_R:  cpu_regs[ra] = cpu_regs[ra] ^ cpu_regs[rb];
            OP_NAND_V: cpu_regs[ra] = ~(cpu_regs[ra] & imm);
            OP_NAND_R: cpu_regs[ra] = ~(cpu_regs[ra] & cpu_regs[rb]);
            OP_NOR_V:  cpu_regs[ra] = ~(cpu_regs[ra] | imm);
            OP_NOR_R:  cpu_regs[ra] = ~(cpu_regs[ra] | cpu_regs[rb]);
            OP_XNOR_V: cpu_regs[ra] = ~(cpu_regs[ra] ^ imm);
            OP_XNOR_R: cpu_regs[ra] = ~(cpu_regs[ra] ^ cpu_regs[rb]);
            OP_NOT:    cpu_regs[ra] = ~cpu_regs[ra];
            OP_MOV_RV: begin
                cpu_regs[ra] = imm;
                jumped = (ra == IP_INDEX);
            end
            OP_MOV_RR: begin
                cpu_regs[ra] = cpu_regs[rb];
                jumped = (ra == IP_INDEX);
            end
            OP_MOV_RM: begin
                if (addr <= ADDR_TOP) cpu_regs[ra] = data_mem[addr];
                else begin
                    cpu_regs[ra] = '0;
                    res.status = ST_BAD_ADR;
                end
                jumped = (ra == IP_INDEX);
            end
            OP_MOV_MR: begin
                if (addr <= ADDR_TOP) data_mem[addr] = cpu_regs[ra];
                else res.status = ST_BAD_ADR;
            end
            OP_MOV_MV: begin
                if (addr <= ADDR_TOP) data_mem[addr] = imm;
                else res.status = ST_BAD_ADR;
            end
            OP_MOV_IV: begin
                ptr = cpu_regs[ra];
                if (ptr <= ADDR_TOP) data_mem[ptr] = imm;
                else res.status = ST_BAD_ADR;
            end
            OP_MOV_RI: begin
                ptr = cpu_regs[rb];
                if (ptr <= ADDR_TOP) begin
                    cpu_regs[ra] = data_mem[ptr];
                    jumped = (ra == IP_INDEX);
                end else res.status = ST_BAD_ADR;
            end
            OP_MOV_IR: begin
                ptr = cpu_regs[ra];
                if (ptr <= ADDR_TOP) data_mem[ptr] = cpu_regs[rb];
                else res.status = ST_BAD_ADR;
            end
            OP_CMP_RR: cmp_flags = compare_u(cpu_regs[ra], cpu_regs[rb]);
            OP_CMP_RV: cmp_flags = compare_u(cpu_regs[ra], imm);
            OP_JMP: begin
                cpu_regs[IP_INDEX] = imm;
                jumped = 1'b1;
            end
            OP_JE, OP_JL, OP_JG: begin
                if ((op == OP_JE && cmp_flags[FLAG_EQ]) || (op == OP_JL && cmp_flags[FLAG_LT])
                        || (op == OP_JG && cmp_flags[FLAG_GT])) begin
                    cpu_regs[IP_INDEX] = imm;
                    jumped = 1'b1;
                end
            end
            OP_OUT: begin
                res.out_valid = 1'b1;
                res.out_value = cpu_regs[ra];
            end
            OP_HLT: cpu_halted = 1'b1;
            default: res.status = ST_BAD_OP;
        endcase
        if (!jumped) cpu_regs[IP_INDEX] = cpu_regs[IP_INDEX] + 1;
        res.next_ip = cpu_regs[IP_INDEX];
        res.halted = cpu_halted;
        return res;
    endfunction

    // Drive one instruction, hold until the transaction completes, then maybe idle.
    task automatic send_instr(logic [7:0] op, logic [2:0] ra, logic [2:0] rb,
            logic [31:0] imm, logic [31:0] addr);
        int gap;
        s_valid       <= 1'b1;
        s_opcode      <= op;
        s_first_reg   <= ra;
        s_second_reg  <= rb;
        s_imm_value   <= imm;
        s_mem_address <= addr;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(execute_instr(op, ra, rb, imm, addr));
        if ($urandom_range(99) < send_idle_pct) begin
            gap = $urandom_range(1, 4);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Receiver back-pressure, redrawn every cycle.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Result checker: compares each completed result transaction with the oldest prediction.
    always @(posedge aclk) begin
        exec_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result transaction ip=%h", $time, m_next_ip);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_next_ip !== want.next_ip) begin
                    $display("%0t: next_ip exp %h got %h", $time, want.next_ip, m_next_ip);
                    error_count++;
                end
                if (m_out_valid !== want.out_valid) begin
                    $display("%0t: out_valid exp %b got %b", $time, want.out_valid,
                             m_out_valid);
                    error_count++;
                end
                if (m_out_value !== want.out_value) begin
                    $display("%0t: out_value exp %h got %h", $time, want.out_value,
                             m_out_value);
                    error_count++;
                end
                if (m_halted !== want.halted) begin
                    $display("%0t: halted exp %b got %b", $time, want.halted, m_halted);
                    error_count++;
                end
                if (m_status !== want.status) begin
                    $display("%0t: status exp %0d got %0d", $time, want.status, m_status);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: any cycle without a transaction on either side counts toward the limit.
    int stall_cycles = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog timeout at %0t", $time);
            $display("status: fail");
            $finish;
        end
    end

    // Directed: wraparound arithmetic, ip readback, out/in, single ops.
    task automatic test_alu_basics();
        send_instr(OP_MOV_RV, 3'd0, 3'd0, 32'hFFFF_FFFF, '0);
        send_instr(OP_ADD_V, 3'd0, 3'd0, 32'd1, '0);          // wraps to zero
        send_instr(OP_SUB_V, 3'd1, 3'd0, 32'd1, '0);          // underflow
        send_instr(OP_MUL_R, 3'd1, 3'd1, '0, '0);
        send_instr(OP_INC, 3'd7, 3'd0, '0, '0);
        send_instr(OP_DEC, 3'd6, 3'd0, '0, '0);
        send_instr(OP_NOT, 3'd2, 3'd0, '0, '0);
        send_instr(OP_MOV_RR, 3'd3, IP_INDEX, '0, '0);        // ip reads as last byte
        send_instr(OP_OUT, 3'd3, 3'd0, '0, '0);
        send_instr(OP_IN, 3'd4, 3'd0, '0, '0);
        send_instr(SPARE_OP, 3'd7, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    // Directed: direct and indirect memory moves at and beyond the address bound.
    task automatic test_memory_bounds();
        send_instr(OP_MOV_MV, 3'd0, 3'd0, 32'hA5A5_5A5A, ADDR_TOP);
        send_instr(OP_MOV_MV, 3'd0, 3'd0, 32'h1234_5678, ADDR_TOP + 1);
        send_instr(OP_MOV_RM, 3'd4, 3'd0, '0, ADDR_TOP);
        send_instr(OP_MOV_RM, 3'd4, 3'd0, '0, 32'hFFFF_FFFF);
        send_instr(OP_MOV_MR, 3'd2, 3'd0, '0, 32'd0);
        send_instr(OP_MOV_RV, 3'd2, 3'd0, ADDR_TOP, '0);
        send_instr(OP_MOV_IV, 3'd2, 3'd0, 32'hDEAD_BEEF, '0);
        send_instr(OP_MOV_RI, 3'd3, 3'd2, '0, '0);
        send_instr(OP_INC, 3'd2, 3'd0, '0, '0);
        send_instr(OP_MOV_IR, 3'd2, 3'd3, '0, '0);
        send_instr(OP_MOV_RI, 3'd3, 3'd2, '0, '0);
        send_instr(OP_MOV_RM, IP_INDEX, 3'd0, '0, ADDR_TOP + 1);  // load of zero jumps
    endtask

    // Directed: each compare outcome, taken and not-taken jumps, writes to ip.
    task automatic test_compare_jumps();
        send_instr(OP_MOV_RV, 3'd0, 3'd0, 32'd7, '0);
        send_instr(OP_CMP_RV, 3'd0, 3'd0, 32'd7, '0);
        send_instr(OP_JE, 3'd0, 3'd0, 32'h0000_0100, '0);
        send_instr(OP_CMP_RV, 3'd0, 3'd0, 32'hFFFF_FFFF, '0);
        send_instr(OP_JG, 3'd0, 3'd0, 32'h0000_0200, '0);       // not taken
        send_instr(OP_JL, 3'd0, 3'd0, 32'h0000_0300, '0);
        send_instr(OP_CMP_RR, 3'd0, 3'd1, '0, '0);
        send_instr(OP_JG, 3'd0, 3'd0, 32'hFFFF_FFFF, '0);
        send_instr(OP_JMP, 3'd0, 3'd0, 32'h8000_0000, '0);
        send_instr(OP_MOV_RV, IP_INDEX, 3'd0, 32'd40, '0);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(3))
            0: return $urandom_range(0, RAM_WORDS + 4);
            1: return $urandom;
            2: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
            default: return $urandom_range(0, 15);
        endcase
    endfunction

    // Random instruction stream; pointer setup is weighted up so indirect forms land in range.
    task automatic test_random_stream(int count);
        logic [7:0] op;
        logic [31:0] addr;
        repeat (count) begin
            case ($urandom_range(19))
                0: op = 8'($urandom_range(8'h21, 8'hFC));        // mostly undefined region
                1, 2: op = OP_MOV_RV;
                default: op = known_ops[$urandom_range(known_ops.size() - 1)];
            endcase
            addr = ($urandom_range(9) == 0) ? $urandom : $urandom_range(0, RAM_WORDS - 1);
            send_instr(op, 3'($urandom_range(7)), 3'($urandom_range(7)), pick_value(), addr);
        end
    endtask

    // Halt, then confirm the core stays frozen.
    task automatic test_halt();
        send_instr(OP_HLT, 3'd0, 3'd0, '0, '0);
        send_instr(OP_INC, 3'd0, 3'd0, '0, '0);
        send_instr(OP_JMP, 3'd0, 3'd0, 32'h55, '0);
        send_instr(OP_OUT, 3'd1, 3'd0, '0, '0);
    endtask

    initial begin
        cpu_regs = '{default: '0};
        cmp_flags = '0;
        cpu_halted = 1'b0;
        foreach (data_mem[i]) data_mem[i] = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 28;
        recv_idle_pct = 74;
        test_alu_basics();
        test_memory_bounds();
        test_compare_jumps();
        test_random_stream(430);
        send_idle_pct = 74;
        recv_idle_pct = 28;
        test_random_stream(430);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_stream(440);
        test_halt();
        s_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
design/scie_pkg.sv
design/scie_ram.sv
design/small_cpu_instruction_execute_core.sv
design/scie_checker.sv
dv/tb.sv
